>>> design/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg: shared definitions for the string-to-integer parser
// Phase and radix codes, character constants, default widths and digit helpers.
// ----------------------------------------------------------------------------
package stip_pkg;

  // Default accumulator width and the fixed width of the result field.
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int CH_WIDTH        = 8;

  // Parse phase codes.
  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Radix mode codes.
  localparam logic [1:0] RM_DEC = 2'd0;
  localparam logic [1:0] RM_HEX = 2'd1;
  localparam logic [1:0] RM_OCT = 2'd2;
  localparam logic [1:0] RM_BIN = 2'd3;

  // Character constants.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // Digit lookup result.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // Fold lower-case letters onto upper case.
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      u = c - 8'd32;
    end
    return u;
  endfunction

  // Digit value of a character in the given radix.
  function automatic digit_t digit_of(input logic [7:0] c, input logic [1:0] mode);
    digit_t     d;
    logic [7:0] u;
    logic [7:0] off;
    u       = upcase(c);
    off     = c - CH_ZERO;
    d.valid = 1'b0;
    d.value = off[3:0];
    unique case (mode)
      RM_HEX: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          d.valid = 1'b1;
        end else if (u >= CH_UP_A && u <= CH_UP_F) begin
          off     = u - CH_UP_A + 8'd10;
          d.valid = 1'b1;
          d.value = off[3:0];
        end
      end
      RM_OCT: d.valid = (c >= CH_ZERO && c <= CH_SEVEN);
      RM_BIN: d.valid = (c >= CH_ZERO && c <= CH_ONE);
      default: d.valid = (c >= CH_ZERO && c <= CH_NINE);
    endcase
    return d;
  endfunction

endpackage

>>> design/string_to_integer_parser_core.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser_core: streaming string-to-integer parser
// Takes one character per request and emits the signed integer at the NUL.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the skid register is empty; no character
// ever waits on the arithmetic. The result appears on out_tvalid in the cycle after its
// NUL is accepted when the result register is free or drains in that cycle, else it
// waits in the skid register. The combinational shift-add on the accumulator sets the rate.
// A two-entry output stage (result register plus skid register) lets input continue
// while a result waits. Synchronous active-low reset returns the parser to the
// leading-space phase, decimal, positive, zero, and empties the output stage.
module string_to_integer_parser_core #(
  parameter int VALUE_WIDTH = stip_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one character per request.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  // Result channel: one parsed value per string.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] value
);

  // Parser state.
  logic [2:0]             phase_r, phase_nxt;
  logic [1:0]             radix_r, radix_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;

  // Output stage: main result register and a skid register behind it.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [31:0] skid_data_r, skid_data_nxt;

  logic                   in_acc;
  logic                   is_nul;
  logic                   res_push;
  logic                   res_pop;
  logic [7:0]             ch;
  logic [7:0]             ch_up;
  stip_pkg::digit_t       dig;
  logic [VALUE_WIDTH-1:0] acc_scaled;
  logic [VALUE_WIDTH-1:0] acc_digit;
  logic [VALUE_WIDTH-1:0] signed_val;
  logic [31:0]            result;
  logic                   take;        // this character is handed to the digit path
  logic [1:0]             take_radix;  // radix the digit path uses

  assign ch        = in_tdata;
  assign ch_up     = stip_pkg::upcase(ch);
  assign is_nul    = (ch == stip_pkg::CH_NUL);
  // The skid register absorbs one result while the main register is stalled,
  // so input is only held off when both are full.
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign res_push  = in_acc && is_nul;
  assign res_pop   = out_valid_r && out_tready;

  // Phase decode decides whether the character goes to the digit path,
  // and under which radix (a leading zero switches to octal on the same digit).
  always_comb begin
    phase_nxt  = phase_r;
    radix_nxt  = radix_r;
    neg_nxt    = neg_r;
    take       = 1'b0;
    take_radix = radix_r;
    unique case (phase_r)
      stip_pkg::PH_SPACE: begin
        if (ch == stip_pkg::CH_SPACE) begin
          phase_nxt = phase_r;
        end else if (ch == stip_pkg::CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = stip_pkg::PH_SIGN;
        end else if (ch == stip_pkg::CH_ZERO) begin
          phase_nxt = stip_pkg::PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      stip_pkg::PH_SIGN: begin
        if (ch == stip_pkg::CH_ZERO) begin
          phase_nxt = stip_pkg::PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      stip_pkg::PH_ZERO: begin
        if (ch_up == stip_pkg::CH_UP_X) begin
          radix_nxt = stip_pkg::RM_HEX;
          phase_nxt = stip_pkg::PH_DIGITS;
        end else if (ch_up == stip_pkg::CH_UP_B) begin
          radix_nxt = stip_pkg::RM_BIN;
          phase_nxt = stip_pkg::PH_DIGITS;
        end else begin
          radix_nxt  = stip_pkg::RM_OCT;
          take_radix = stip_pkg::RM_OCT;
          take       = 1'b1;
        end
      end
      stip_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        // Error phase, and the unused codes, swallow everything up to the NUL.
        phase_nxt = phase_r;
      end
    endcase
  end

  // Digit path: multiply by the base with shifts, then add the digit.
  assign dig = stip_pkg::digit_of(ch, take_radix);

  always_comb begin
    unique case (take_radix)
      stip_pkg::RM_HEX: acc_scaled = acc_r << 4;
      stip_pkg::RM_OCT: acc_scaled = acc_r << 3;
      stip_pkg::RM_BIN: acc_scaled = acc_r << 1;
      default:          acc_scaled = (acc_r << 3) + (acc_r << 1);
    endcase
    acc_digit = acc_scaled + {{(VALUE_WIDTH-4){1'b0}}, dig.value};
  end

  // Final value: negate if a minus was seen, then fit to the 32-bit field.
  assign signed_val = neg_r ? (~acc_r + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : acc_r;

  generate
    if (VALUE_WIDTH >= stip_pkg::OUT_WIDTH) begin : g_trunc
      assign result = signed_val[stip_pkg::OUT_WIDTH-1:0];
    end else begin : g_sext
      assign result = {{(stip_pkg::OUT_WIDTH-VALUE_WIDTH){signed_val[VALUE_WIDTH-1]}},
                       signed_val};
    end
  endgenerate

  // Next state of the accumulator and final phase resolution.
  logic [2:0] phase_fin;
  always_comb begin
    acc_nxt   = acc_r;
    phase_fin = phase_nxt;
    if (take) begin
      if (dig.valid) begin
        acc_nxt   = acc_digit;
        phase_fin = stip_pkg::PH_DIGITS;
      end else begin
        acc_nxt   = '0;
        phase_fin = stip_pkg::PH_ERROR;
      end
    end
  end

  // Output stage control.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // No input is taken while the skid register is full.
      if (res_pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_r || res_pop) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end else if (res_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= stip_pkg::PH_SPACE;
      radix_r      <= stip_pkg::RM_DEC;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (in_acc) begin
        if (is_nul) begin
          // A finished string returns the parser to its start state.
          phase_r <= stip_pkg::PH_SPACE;
          radix_r <= stip_pkg::RM_DEC;
          neg_r   <= 1'b0;
          acc_r   <= '0;
        end else begin
          phase_r <= phase_fin;
          radix_r <= radix_nxt;
          neg_r   <= neg_nxt;
          acc_r   <= acc_nxt;
        end
      end
    end
  end

  // Result payload registers need no reset.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // The skid register only ever holds a result behind a stalled main register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  // A NUL always returns the parser to its start state.
  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_nul) |=> (phase_r == stip_pkg::PH_SPACE && acc_r == '0 && !neg_r
                            && radix_r == stip_pkg::RM_DEC))
    else $error("parser state not cleared after NUL");

  // The error phase keeps a zero accumulator.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == stip_pkg::PH_ERROR) |-> (acc_r == '0))
    else $error("accumulator nonzero in error phase");

  // Once in error, only a NUL leaves it.
  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == stip_pkg::PH_ERROR && !(in_acc && is_nul)) |=>
      (phase_r == stip_pkg::PH_ERROR))
    else $error("left error phase without NUL");

  // A NUL accepted while the result register is empty always presents a result there.
  a_result_on_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_nul && !out_valid_r) |=> out_valid_r)
    else $error("NUL accepted but no result presented");
`endif

endmodule

>>> bench/string_to_integer_parser_checker.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser_checker: result predictor and scoreboard
// Watches both stream channels, computes the value each string should parse
// to and compares every returned value with the oldest one still owed.
// ----------------------------------------------------------------------------
module string_to_integer_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          mismatch_count,
  output int          awaited_count,
  output int          value_count,
  output int          rejected_count
);

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } char_digit_t;

  logic [2:0]  phase_q;
  logic [1:0]  radix_q;
  logic        negative_q;
  logic [31:0] acc_q;
  logic [31:0] owed_values[$];

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= stip_pkg::CH_LO_A && c <= stip_pkg::CH_LO_Z) ? c - 8'd32 : c;
  endfunction

  function automatic char_digit_t decode_digit(input logic [7:0] c, input logic [1:0] radix);
    char_digit_t r;
    logic [7:0]  folded;
    folded = fold_case(c);
    r.val  = c[3:0];
    case (radix)
      stip_pkg::RM_HEX: begin
        r.ok = (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_NINE);
        if (folded >= stip_pkg::CH_UP_A && folded <= stip_pkg::CH_UP_F) begin
          r.ok  = 1'b1;
          r.val = 4'(folded - stip_pkg::CH_UP_A + 8'd10);
        end
      end
      stip_pkg::RM_OCT: r.ok = (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_SEVEN);
      stip_pkg::RM_BIN: r.ok = (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_ONE);
      default:          r.ok = (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_NINE);
    endcase
    return r;
  endfunction

  task automatic clear_parse();
    phase_q    = stip_pkg::PH_SPACE;
    radix_q    = stip_pkg::RM_DEC;
    negative_q = 1'b0;
    acc_q      = '0;
  endtask

  task automatic take_digit(input logic [7:0] c);
    char_digit_t d;
    logic [31:0] base;
    d = decode_digit(c, radix_q);
    case (radix_q)
      stip_pkg::RM_HEX: base = 32'd16;
      stip_pkg::RM_OCT: base = 32'd8;
      stip_pkg::RM_BIN: base = 32'd2;
      default:          base = 32'd10;
    endcase
    if (!d.ok) begin
      acc_q   = '0;
      phase_q = stip_pkg::PH_ERROR;
    end else begin
      acc_q   = acc_q * base + 32'(d.val);
      phase_q = stip_pkg::PH_DIGITS;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    if (c == stip_pkg::CH_NUL) begin
      if (phase_q == stip_pkg::PH_ERROR) begin
        rejected_count++;
      end
      owed_values.push_back(negative_q ? 32'd0 - acc_q : acc_q);
      clear_parse();
    end else begin
      case (phase_q)
        stip_pkg::PH_SPACE: begin
          if (c == stip_pkg::CH_MINUS) begin
            negative_q = 1'b1;
            phase_q    = stip_pkg::PH_SIGN;
          end else if (c == stip_pkg::CH_ZERO) begin
            phase_q = stip_pkg::PH_ZERO;
          end else if (c != stip_pkg::CH_SPACE) begin
            take_digit(c);
          end
        end
        stip_pkg::PH_SIGN: begin
          if (c == stip_pkg::CH_ZERO) begin
            phase_q = stip_pkg::PH_ZERO;
          end else begin
            take_digit(c);
          end
        end
        stip_pkg::PH_ZERO: begin
          if (fold_case(c) == stip_pkg::CH_UP_X) begin
            radix_q = stip_pkg::RM_HEX;
            phase_q = stip_pkg::PH_DIGITS;
          end else if (fold_case(c) == stip_pkg::CH_UP_B) begin
            radix_q = stip_pkg::RM_BIN;
            phase_q = stip_pkg::PH_DIGITS;
          end else begin
            radix_q = stip_pkg::RM_OCT;
            take_digit(c);
          end
        end
        stip_pkg::PH_DIGITS: take_digit(c);
        default: ;
      endcase
    end
  endtask

  // Results are checked before the character of the same edge is parsed; a
  // value can never leave in the cycle its terminator is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      owed_values.delete();
      mismatch_count = 0;
      value_count    = 0;
      rejected_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_values.size() == 0) begin
          $error("value: unexpected result, expected none, actual %0d", $signed(out_tdata));
          mismatch_count++;
        end else begin
          if (out_tdata !== owed_values[0]) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(owed_values[0]), $signed(out_tdata));
            mismatch_count++;
          end
          void'(owed_values.pop_front());
          value_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        parse_char(in_tdata);
      end
    end
    awaited_count = owed_values.size();
  end

endmodule

>>> bench/string_to_integer_parser_core_test.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser_core_test: stimulus and verdict for the parser
// Streams directed and random strings into the parser under random sender
// gaps and receiver stalls; a side checker predicts and compares the values.
// ----------------------------------------------------------------------------
module string_to_integer_parser_core_test;

  // Characters of the random part; the directed part of about 110 characters
  // comes on top.
  localparam int RANDOM_CHARS = 1140;
  // Hard stop for the whole run, in time units (two per clock cycle).
  localparam int RUN_LIMIT    = 4000000;
  // Cycles one drain may take before the missing results count as failures.
  localparam int DRAIN_BOUND  = 5000;

  // Receiver behaviors: always ready, coin toss, mostly stalled, and a
  // rotating 16-bit ready pattern.
  localparam logic [1:0] RX_OPEN    = 2'd0;
  localparam logic [1:0] RX_COIN    = 2'd1;
  localparam logic [1:0] RX_CHOKE   = 2'd2;
  localparam logic [1:0] RX_PATTERN = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  int          mismatch_count;
  int          awaited_count;
  int          value_count;
  int          rejected_count;

  int          burst_left;
  int          sent_chars;
  int          random_start;
  logic        drain_stuck;

  logic [1:0]  rx_mode;
  int          rx_hold;
  logic [15:0] rx_pattern;

  always #1 clk = ~clk;

  string_to_integer_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  string_to_integer_parser_checker value_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .value_count    (value_count),
    .rejected_count (rejected_count)
  );

  // The receiver picks a behavior, keeps it for a random stretch and then
  // picks again, so stalls land on every phase of a string, including the
  // cycle right after a terminator and stretches where both entries of the
  // output stage fill up.
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode    = 2'($urandom_range(0, 3));
      rx_hold    = $urandom_range(16, 160);
      rx_pattern = 16'($urandom);
    end
    rx_hold--;
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_tready <= ($urandom_range(0, 4) == 0);
      RX_PATTERN: begin
        out_tready <= rx_pattern[0];
        rx_pattern  = {rx_pattern[0], rx_pattern[15:1]};
      end
      default:  out_tready <= 1'b1;
    endcase
  end

  // Sends one character as one request. The sender works in bursts; at the
  // start of a new burst it usually drops valid first. It returns at the
  // falling edge after the request was taken, so a following call keeps
  // valid high without a glitch.
  task automatic send_char(input logic [7:0] c);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent_chars++;
  endtask

  // Sends the characters of s followed by the terminating NUL.
  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    send_char(stip_pkg::CH_NUL);
  endtask

  // Stops sending and waits until every owed value has come back or the drain
  // bound runs out. Always waits for a falling edge first so valid is never
  // lowered and raised in the same step.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0 && waited < DRAIN_BOUND) begin
      @(negedge clk);
      waited++;
    end
    if (awaited_count != 0) begin
      $error("value: %0d expected results never arrived", awaited_count);
      drain_stuck = 1'b1;
    end
  endtask

  // A random character that is a valid digit in the given radix. Hex letters
  // come in either case.
  function automatic logic [7:0] radix_digit(input logic [1:0] radix);
    int n;
    case (radix)
      stip_pkg::RM_HEX: begin
        n = $urandom_range(0, 15);
        if (n < 10) begin
          return 8'(stip_pkg::CH_ZERO + n);
        end
        return 8'(($urandom_range(0, 1) ? stip_pkg::CH_UP_A : stip_pkg::CH_LO_A)
                  + n - 10);
      end
      stip_pkg::RM_OCT: return 8'(stip_pkg::CH_ZERO + $urandom_range(0, 7));
      stip_pkg::RM_BIN: return 8'(stip_pkg::CH_ZERO + $urandom_range(0, 1));
      default:          return 8'(stip_pkg::CH_ZERO + $urandom_range(0, 9));
    endcase
  endfunction

  // A character that looks like a digit but is out of range for the radix.
  function automatic logic [7:0] foreign_digit(input logic [1:0] radix);
    case (radix)
      stip_pkg::RM_HEX: return 8'(stip_pkg::CH_UP_F + $urandom_range(1, 20));
      stip_pkg::RM_OCT: return 8'(stip_pkg::CH_SEVEN + $urandom_range(1, 2));
      stip_pkg::RM_BIN: return 8'(stip_pkg::CH_ONE + $urandom_range(1, 8));
      default:          return 8'(stip_pkg::CH_UP_A + $urandom_range(0, 25));
    endcase
  endfunction

  // One random number string: optional leading spaces, optional minus, a
  // radix prefix, and a digit run that is mostly short and now and then long
  // enough to wrap. About a third of the strings get one bad character at a
  // random spot: a stray byte, a space, a second minus, an out-of-range digit
  // or a byte with the top bit set, sometimes with one more digit at the end.
  task automatic send_random_number();
    logic [7:0] text[$];
    logic [1:0] radix;
    logic [7:0] junk;
    int         digits;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(stip_pkg::CH_SPACE);
    end
    if ($urandom_range(0, 2) == 0) begin
      text.push_back(stip_pkg::CH_MINUS);
    end
    radix  = 2'($urandom_range(0, 3));
    digits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 34) : $urandom_range(0, 8);
    case (radix)
      stip_pkg::RM_HEX: begin
        text.push_back(stip_pkg::CH_ZERO);
        text.push_back($urandom_range(0, 1) ? stip_pkg::CH_UP_X
                                            : 8'(stip_pkg::CH_UP_X + 8'd32));
      end
      stip_pkg::RM_BIN: begin
        text.push_back(stip_pkg::CH_ZERO);
        text.push_back($urandom_range(0, 1) ? stip_pkg::CH_UP_B
                                            : 8'(stip_pkg::CH_UP_B + 8'd32));
      end
      stip_pkg::RM_OCT: text.push_back(stip_pkg::CH_ZERO);
      default: begin
        // A decimal run must not start with zero, or it turns octal.
        if (digits > 0) begin
          text.push_back(8'(stip_pkg::CH_ONE + $urandom_range(0, 8)));
          digits--;
        end
      end
    endcase
    repeat (digits) text.push_back(radix_digit(radix));
    if ($urandom_range(0, 99) < 30) begin
      case ($urandom_range(0, 4))
        0:       junk = 8'($urandom_range(1, 255));
        1:       junk = stip_pkg::CH_SPACE;
        2:       junk = stip_pkg::CH_MINUS;
        3:       junk = foreign_digit(radix);
        default: junk = 8'($urandom_range(128, 255));
      endcase
      text.insert($urandom_range(0, text.size()), junk);
      if ($urandom_range(0, 1)) begin
        text.push_back(radix_digit(radix));
      end
    end
    foreach (text[i]) begin
      send_char(text[i]);
    end
    send_char(stip_pkg::CH_NUL);
  endtask

  // A short run of arbitrary non-NUL bytes; this is where every bit of the
  // character field gets exercised.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(1, 255)));
    send_char(stip_pkg::CH_NUL);
  endtask

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin
    #(RUN_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    burst_left  = 0;
    sent_chars  = 0;
    drain_stuck = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings: empty and blank input, lone prefixes, misplaced
    // spaces and minus signs, the signed extremes, wrapping, both hex cases,
    // digits out of range for octal and binary, and high-bit bytes.
    send_string("");
    send_string("   ");
    send_string("0");
    send_string("0x");
    send_string("0B");
    send_string("- 5");
    send_string("--1");
    send_string("12 ");
    send_string("  -42");
    send_string("2147483647");
    send_string("-2147483648");
    send_string("4294967297");
    send_string("0xDeadBEEF");
    send_string("-0x1");
    send_string("017");
    send_string("08");
    send_string("0b1011");
    send_string("0b102");
    send_string("-0");
    send_string("9z");
    send_char(8'hFF);
    send_char(8'h80);
    send_char(stip_pkg::CH_NUL);

    // Let everything come back before the random part begins.
    wait_for_results();

    random_start = sent_chars;
    while (sent_chars - random_start < RANDOM_CHARS) begin
      if ($urandom_range(0, 19) == 0) begin
        send_noise();
      end else begin
        send_random_number();
      end
      if ($urandom_range(0, 39) == 0) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (8) @(negedge clk);

    $display("Run covered %0d characters: directed corner strings, random numbers in all four",
             sent_chars);
    $display("radixes with wrapping and injected faults, and noise; %0d values, %0d invalid.",
             value_count, rejected_count);
    if (mismatch_count == 0 && !drain_stuck) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/stip_pkg.sv
design/string_to_integer_parser_core.sv
bench/string_to_integer_parser_checker.sv
bench/string_to_integer_parser_core_test.sv
